FILE: hdl/discrete_cdf_bin_sampler_defines.svh
// assertion macros shared by the sampler rtl
`ifndef DISCRETE_CDF_BIN_SAMPLER_DEFINES_SVH
`define DISCRETE_CDF_BIN_SAMPLER_DEFINES_SVH

// same-cycle implication, clocked on aclk, off during reset
`define DCBS_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off during reset
`define DCBS_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/dcbs_pkg.sv
// shared types and constants of the cdf bin sampler
`default_nettype none

package dcbs_pkg;

    // request codes on the input channel
    typedef enum logic [0:0] {
        REQ_WRITE  = 1'b0,
        REQ_SAMPLE = 1'b1
    } req_t;

    // register word select (paddr bit 2)
    localparam logic REG_BIN_COUNT = 1'b0;

    // fixed field widths
    localparam int CFG_W  = 9;
    localparam int IDX_W  = 8;
    localparam int BIN_W  = 8;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

endpackage

`default_nettype wire

FILE: hdl/dcbs_table.sv
// cumulative table memory, one write port and one registered read port
`default_nettype none

module dcbs_table #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int VAL_W  = 17
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [VAL_W-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [VAL_W-1:0]  rd_data
);

    logic [VAL_W-1:0] mem [DEPTH];
    logic [VAL_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read every cycle
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: hdl/dcbs_cell.sv
// one level of the lower-bound search: holds a window and narrows it
`default_nettype none

module dcbs_cell #(
    parameter int CNT_W  = 9,
    parameter int ADDR_W = 8,
    parameter int VAL_W  = 17
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // window handed in from the previous level
    input  wire logic              in_valid,
    input  wire logic [CNT_W-1:0]  in_first,
    input  wire logic [CNT_W-1:0]  in_count,
    input  wire logic [VAL_W-1:0]  in_key,
    // probe address for the incoming window, zero when idle
    output logic      [ADDR_W-1:0] rd_addr,
    // table entry at the probe of the held window
    input  wire logic [VAL_W-1:0]  rd_data,
    // narrowed window handed to the next level
    output logic                   out_valid,
    output logic      [CNT_W-1:0]  out_first,
    output logic      [CNT_W-1:0]  out_count,
    output logic      [VAL_W-1:0]  out_key
);

    logic             valid_reg;
    logic [CNT_W-1:0] first_reg;
    logic [CNT_W-1:0] count_reg;
    logic [VAL_W-1:0] key_reg;
    logic [CNT_W-1:0] in_probe;
    logic [CNT_W-1:0] half;

    // probe of the window about to be captured
    assign in_probe = in_first + (in_count >> 1);
    assign rd_addr  = in_valid ? in_probe[ADDR_W-1:0] : '0;

    // token bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= in_valid;
        end
    end

    // window payload
    always_ff @(posedge aclk) begin
        if (in_valid) begin
            first_reg <= in_first;
            count_reg <= in_count;
            key_reg   <= in_key;
        end
    end

    // narrow the window on the compare result
    assign half = count_reg >> 1;

    always_comb begin
        out_first = first_reg;
        out_count = count_reg;
        if (count_reg != '0) begin
            if (rd_data < key_reg) begin
                out_first = first_reg + half + CNT_W'(1);
                out_count = count_reg - half - CNT_W'(1);
            end else begin
                out_count = half;
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_key   = key_reg;

endmodule

`default_nettype wire

FILE: hdl/discrete_cdf_bin_sampler.sv
// Discrete inverse-cdf sampler. A write transaction stores one cumulative value
// (unsigned, FRAC_BITS fraction bits) in the table. A sample transaction runs a
// lower-bound binary search over the bins in use through a chain of
// clog2(MAX_BINS+1) search cells, one level per cycle, all sharing the single
// read port of the table memory; the next transaction is taken only once the
// search has left the last cell. One search is in flight at a time; an output
// register plus one holding slot let the next transaction start while a result
// waits. When no bin qualifies the index saturates to the last bin in use and
// m_no_bin_found is set. Bin count zero counts as one bin, values above MAX_BINS
// saturate. Table entries have no reset and must be written before a search can
// reach them.
`default_nettype none

`include "discrete_cdf_bin_sampler_defines.svh"

module discrete_cdf_bin_sampler #(
    parameter int MAX_BINS  = 256,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // apb configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [dcbs_pkg::APB_AW-1:0]    paddr,
    input  wire logic [dcbs_pkg::APB_DW-1:0]    pwdata,
    output logic      [dcbs_pkg::APB_DW-1:0]    prdata,
    output logic                                pready,
    // request channel
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_req_type,
    input  wire logic [dcbs_pkg::IDX_W-1:0]     s_entry_index,
    input  wire logic [FRAC_BITS:0]             s_cdf_value,
    input  wire logic [FRAC_BITS:0]             s_random_value,
    // result channel
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic      [dcbs_pkg::BIN_W-1:0]     m_bin_index,
    output logic                                m_no_bin_found
);

    localparam int VAL_W  = FRAC_BITS + 1;
    localparam int ADDR_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int CNT_W  = $clog2(MAX_BINS + 1);
    localparam int LEVELS = $clog2(MAX_BINS + 1);

    logic [dcbs_pkg::CFG_W-1:0] bin_count_reg;
    logic [CNT_W-1:0]           n_use;
    logic                       s_take;
    logic                       launch;
    logic                       wr_en;
    logic [ADDR_W-1:0]          rd_addr;
    logic [VAL_W-1:0]           rd_data;

    logic [LEVELS:0]            chain_valid;
    logic [CNT_W-1:0]           chain_first [LEVELS+1];
    logic [CNT_W-1:0]           chain_count [LEVELS+1];
    logic [VAL_W-1:0]           chain_key   [LEVELS+1];
    logic [ADDR_W-1:0]          cell_addr   [LEVELS];

    logic                       done;
    logic                       fin_miss;
    logic [CNT_W-1:0]           fin_pos;
    logic [dcbs_pkg::BIN_W-1:0] fin_bin;

    logic                       m_valid_reg,    m_valid_next;
    logic [dcbs_pkg::BIN_W-1:0] m_bin_reg,      m_bin_next;
    logic                       m_miss_reg,     m_miss_next;
    logic                       hold_valid_reg, hold_valid_next;
    logic [dcbs_pkg::BIN_W-1:0] hold_bin_reg,   hold_bin_next;
    logic                       hold_miss_reg,  hold_miss_next;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_count_reg <= dcbs_pkg::CFG_W'(1);
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == dcbs_pkg::REG_BIN_COUNT)) begin
            bin_count_reg <= pwdata[dcbs_pkg::CFG_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == dcbs_pkg::REG_BIN_COUNT)
                    ? dcbs_pkg::APB_DW'(bin_count_reg) : '0;

    // bins in use, clamped to one..MAX_BINS
    always_comb begin
        if (bin_count_reg == '0) begin
            n_use = CNT_W'(1);
        end else if (int'(bin_count_reg) > MAX_BINS) begin
            n_use = CNT_W'(MAX_BINS);
        end else begin
            n_use = CNT_W'(bin_count_reg);
        end
    end

    // request acceptance: search chain empty and holding slot free
    assign s_ready = ~(|chain_valid[LEVELS:1]) && !hold_valid_reg;
    assign s_take  = s_valid && s_ready;
    assign launch  = s_take && (s_req_type == dcbs_pkg::REQ_SAMPLE);
    assign wr_en   = s_take && (s_req_type == dcbs_pkg::REQ_WRITE)
                     && (int'(s_entry_index) < MAX_BINS);

    // window entering the first cell
    assign chain_valid[0] = launch;
    assign chain_first[0] = '0;
    assign chain_count[0] = n_use;
    assign chain_key[0]   = s_random_value;

    dcbs_table #(
        .DEPTH  (MAX_BINS),
        .ADDR_W (ADDR_W),
        .VAL_W  (VAL_W)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (ADDR_W'(s_entry_index)),
        .wr_data (s_cdf_value),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // search cells, one per level
    for (genvar k = 0; k < LEVELS; k++) begin : g_cell
        dcbs_cell #(
            .CNT_W  (CNT_W),
            .ADDR_W (ADDR_W),
            .VAL_W  (VAL_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[k]),
            .in_first  (chain_first[k]),
            .in_count  (chain_count[k]),
            .in_key    (chain_key[k]),
            .rd_addr   (cell_addr[k]),
            .rd_data   (rd_data),
            .out_valid (chain_valid[k+1]),
            .out_first (chain_first[k+1]),
            .out_count (chain_count[k+1]),
            .out_key   (chain_key[k+1])
        );
    end

    // shared read address: only the cell taking the token drives a non-zero term
    always_comb begin
        rd_addr = '0;
        for (int k = 0; k < LEVELS; k++) begin
            rd_addr = rd_addr | cell_addr[k];
        end
    end

    // final window to bin index, saturate on a miss
    assign done     = chain_valid[LEVELS];
    assign fin_miss = (chain_first[LEVELS] >= n_use);
    assign fin_pos  = fin_miss ? (n_use - CNT_W'(1)) : chain_first[LEVELS];
    assign fin_bin  = dcbs_pkg::BIN_W'(fin_pos);

    // output register and holding slot
    always_comb begin
        m_valid_next    = m_valid_reg;
        m_bin_next      = m_bin_reg;
        m_miss_next     = m_miss_reg;
        hold_valid_next = hold_valid_reg;
        hold_bin_next   = hold_bin_reg;
        hold_miss_next  = hold_miss_reg;
        if (done) begin
            if (!m_valid_reg || m_ready) begin
                m_valid_next = 1'b1;
                m_bin_next   = fin_bin;
                m_miss_next  = fin_miss;
            end else begin
                hold_valid_next = 1'b1;
                hold_bin_next   = fin_bin;
                hold_miss_next  = fin_miss;
            end
        end else if (m_valid_reg && m_ready) begin
            m_valid_next    = hold_valid_reg;
            m_bin_next      = hold_bin_reg;
            m_miss_next     = hold_miss_reg;
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_bin_reg     <= m_bin_next;
        m_miss_reg    <= m_miss_next;
        hold_bin_reg  <= hold_bin_next;
        hold_miss_reg <= hold_miss_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_bin_index    = m_bin_reg;
    assign m_no_bin_found = m_miss_reg;

    // checks
    `DCBS_ASSERT_IMP(a_single_search, 1'b1, $onehot0(chain_valid[LEVELS:1]), "more than one search in flight")
    `DCBS_ASSERT_IMP(a_hold_behind_out, hold_valid_reg, m_valid_reg, "holding slot full while output empty")
    `DCBS_ASSERT_IMP(a_sample_latency, launch, ##LEVELS done, "search did not finish in the expected number of levels")
    `DCBS_ASSERT_NXT(a_done_parked, done && m_valid_reg && !m_ready, hold_valid_reg, "finished search not parked in holding slot")
    `DCBS_ASSERT_IMP(a_no_overflow, done && hold_valid_reg, 1'b0, "finished search with holding slot full")

endmodule

`default_nettype wire
